// File: design/qfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qfp_pkg;

	localparam int unsigned DEN_W = 31;
	localparam int unsigned QUOT_W = 33;
	localparam int unsigned MAG_W = 63;
	localparam int unsigned ACC_W = 72;
	localparam int unsigned TOL_SHIFT = 16;

	localparam logic [1:0] REG_COEF_SQUARE = 2'd0;
	localparam logic [1:0] REG_COEF_LINEAR = 2'd1;
	localparam logic [1:0] REG_COEF_CONSTANT = 2'd2;
	localparam logic [1:0] REG_REL_TOLERANCE = 2'd3;

	localparam logic [1:0] ST_EXACT = 2'd0;
	localparam logic [1:0] ST_CONVERGED = 2'd1;
	localparam logic [1:0] ST_BAD_BRACKET = 2'd2;
	localparam logic [1:0] ST_ITER_LIMIT = 2'd3;

	localparam logic signed [63:0] F_LIMIT = 64'sh2000_0000_0000_0000;

	typedef enum logic [1:0] {
		EV_LOW,
		EV_HIGH,
		EV_MID
	} ev_sel_t;

endpackage
`default_nettype wire

// File: design/qfp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module qfp_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [qfp_pkg::DEN_W-1:0]   num,
	input  wire logic [qfp_pkg::DEN_W-1:0]   den,
	output logic                             done,
	output logic [qfp_pkg::QUOT_W-1:0]       quot
);
	import qfp_pkg::*;

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] quot_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              first_q;
	logic              done_q;
	logic [DEN_W:0]    cand;
	logic              take;

	always_comb begin
		cand = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
		take = cand >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= 6'(QUOT_W);
				rem_q   <= num;
				den_q   <= den;
				quot_q  <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				rem_q   <= take ? DEN_W'(cand - {1'b0, den_q}) : DEN_W'(cand);
				quot_q  <= {quot_q[QUOT_W-2:0], take};
				cnt_q   <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// File: design/quadratic_false_position_root_top.sv
// false position root finder for a*x^2 + b*x + c, signed fixed point
// input channel: bracket_low and bracket_high under in_valid / in_ready
// output channel: root, status, iterations under out_valid / out_ready
// coefficients and tolerance must be written over the apb port only while idle;
// the block does not enforce it; pready is always high, reads return the register value
// one item at a time: in_ready is high only while the sequencer is idle
// each evaluation of f runs through states S_E0 to S_E6 on the shared 32x32 multiplier
// each false position step runs set-up, the normalising shift, the serial
// divider, the multiplier for the step, one evaluation, and then the update
// and convergence test
// an item takes at most MAX_ITER steps
// an end-point zero or a bad bracket gives its item after the two end-point evaluations
// a finished item waits in the output register while out_ready is low;
// the next item is accepted meanwhile, and its result is held until the
// output register frees
// reset returns the coefficients to a=1, b=0, c=-1, tolerance 66, and
// drops any item in flight
`timescale 1ns / 1ps
`default_nettype none
module quadratic_false_position_root_top #(
	parameter int unsigned MAX_ITER = 64,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] bracket_low,
	input  wire logic [31:0] bracket_high,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      root,
	output logic [1:0]       status,
	output logic [10:0]      iterations
);
	import qfp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6,
		S_CHECK, S_SINIT, S_NORM, S_DIV, S_M0, S_M1, S_UPD, S_C0, S_C1, S_OUT
	} state_t;

	state_t state_q;
	ev_sel_t ev_sel_q;

	logic [15:0] coef_square_q, coef_linear_q, coef_constant_q, rel_tolerance_q;

	logic [31:0] lo_q, hi_q, ev_x_q;
	logic signed [63:0] flo_q, fhi_q, f0_q, t_q;
	logic [63:0] prod_q, sq_q;
	logic [ACC_W-1:0] acc_q;
	logic [MAG_W-1:0] num_q, den_q;
	logic [QUOT_W-1:0] quot;
	logic [10:0] n_q;
	logic [31:0] res_root_q;
	logic [1:0] res_status_q;
	logic [10:0] res_iter_q;
	logic out_valid_q;
	logic [31:0] root_q;
	logic [1:0] status_q;
	logic [10:0] iter_q;

	logic div_start, div_done;
	logic cfg_wr;
	logic [31:0] ax, mul_a, mul_b, adx, ahi, step;
	logic [15:0] aa, ab;
	logic [63:0] prod;
	logic signed [32:0] lo33, hi33, dx, x0_33, sum33;
	logic [61:0] t2mag, mflo, mfhi;
	logic signed [63:0] t2, t1, c_term, fsum, fval;
	logic [63:0] lhs;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_COEF_SQUARE:   prdata = {16'b0, coef_square_q};
			REG_COEF_LINEAR:   prdata = {16'b0, coef_linear_q};
			REG_COEF_CONSTANT: prdata = {16'b0, coef_constant_q};
			REG_REL_TOLERANCE: prdata = {16'b0, rel_tolerance_q};
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		ax = ev_x_q[31] ? 32'(-ev_x_q) : ev_x_q;
		aa = coef_square_q[15] ? 16'(-coef_square_q) : coef_square_q;
		ab = coef_linear_q[15] ? 16'(-coef_linear_q) : coef_linear_q;
		lo33 = $signed({lo_q[31], lo_q});
		hi33 = $signed({hi_q[31], hi_q});
		dx = hi33 - lo33;
		adx = dx[32] ? 32'(-dx) : 32'(dx);
		ahi = hi_q[31] ? 32'(-hi_q) : hi_q;
		sum33 = lo33 + hi33;
		mflo = flo_q[63] ? 62'(-flo_q) : 62'(flo_q);
		mfhi = fhi_q[63] ? 62'(-fhi_q) : 62'(fhi_q);
		step = quot[QUOT_W-1] ? adx : prod_q[63:32];
		x0_33 = dx[32] ? lo33 - $signed({1'b0, step}) : lo33 + $signed({1'b0, step});
		lhs = 64'({adx, 16'b0});
		t2mag = (acc_q > ACC_W'(F_LIMIT)) ? 62'(F_LIMIT) : acc_q[61:0];
		t2 = coef_square_q[15] ? -$signed({2'b0, t2mag}) : $signed({2'b0, t2mag});
		t1 = (coef_linear_q[15] ^ ev_x_q[31]) ? -$signed(prod_q) : $signed(prod_q);
		c_term = $signed({{48{coef_constant_q[15]}}, coef_constant_q}) <<< FRAC_BITS;
		fsum = t_q + c_term;
		if (fsum > F_LIMIT) begin
			fval = F_LIMIT;
		end else if (fsum < -F_LIMIT) begin
			fval = -F_LIMIT;
		end else begin
			fval = fsum;
		end
	end

	always_comb begin
		case (state_q)
			S_E0: begin
				mul_a = ax;
				mul_b = ax;
			end
			S_E2: begin
				mul_a = sq_q[31:0];
				mul_b = {16'b0, aa};
			end
			S_E3: begin
				mul_a = sq_q[63:32];
				mul_b = {16'b0, aa};
			end
			S_E4: begin
				mul_a = {16'b0, ab};
				mul_b = ax;
			end
			S_M0: begin
				mul_a = adx;
				mul_b = quot[31:0];
			end
			S_C0: begin
				mul_a = {16'b0, rel_tolerance_q};
				mul_b = ahi;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	assign div_start = (state_q == S_NORM) && (den_q[MAG_W-1:DEN_W] == '0);

	qfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[DEN_W-1:0]),
		.den    (den_q[DEN_W-1:0]),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_square_q   <= 16'h0001;
			coef_linear_q   <= 16'h0000;
			coef_constant_q <= 16'hFFFF;
			rel_tolerance_q <= 16'd66;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_COEF_SQUARE:   coef_square_q <= pwdata[15:0];
				REG_COEF_LINEAR:   coef_linear_q <= pwdata[15:0];
				REG_COEF_CONSTANT: coef_constant_q <= pwdata[15:0];
				REG_REL_TOLERANCE: rel_tolerance_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ev_sel_q    <= EV_LOW;
			out_valid_q <= 1'b0;
			n_q         <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						lo_q     <= bracket_low;
						hi_q     <= bracket_high;
						ev_x_q   <= bracket_low;
						ev_sel_q <= EV_LOW;
						n_q      <= '0;
						state_q  <= S_E0;
					end
				end
				S_E0: begin
					prod_q  <= prod;
					state_q <= S_E1;
				end
				S_E1: begin
					sq_q    <= prod_q >> FRAC_BITS;
					state_q <= S_E2;
				end
				S_E2: begin
					prod_q  <= prod;
					state_q <= S_E3;
				end
				S_E3: begin
					acc_q   <= ACC_W'(prod_q);
					prod_q  <= prod;
					state_q <= S_E4;
				end
				S_E4: begin
					acc_q   <= acc_q + (ACC_W'(prod_q) << 32);
					prod_q  <= prod;
					state_q <= S_E5;
				end
				S_E5: begin
					t_q     <= t2 + t1;
					state_q <= S_E6;
				end
				S_E6: begin
					case (ev_sel_q)
						EV_LOW: begin
							flo_q    <= fval;
							ev_x_q   <= hi_q;
							ev_sel_q <= EV_HIGH;
							state_q  <= S_E0;
						end
						EV_HIGH: begin
							fhi_q   <= fval;
							state_q <= S_CHECK;
						end
						default: begin
							f0_q    <= fval;
							state_q <= S_UPD;
						end
					endcase
				end
				S_CHECK: begin
					if (flo_q == '0) begin
						res_root_q   <= lo_q;
						res_status_q <= ST_EXACT;
						res_iter_q   <= '0;
						state_q      <= S_OUT;
					end else if (fhi_q == '0) begin
						res_root_q   <= hi_q;
						res_status_q <= ST_EXACT;
						res_iter_q   <= '0;
						state_q      <= S_OUT;
					end else if (flo_q[63] == fhi_q[63]) begin
						res_root_q   <= '0;
						res_status_q <= ST_BAD_BRACKET;
						res_iter_q   <= '0;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_SINIT;
					end
				end
				S_SINIT: begin
					num_q   <= MAG_W'(mflo);
					den_q   <= MAG_W'(mflo) + MAG_W'(mfhi);
					n_q     <= n_q + 11'd1;
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						num_q <= num_q >> 1;
						den_q <= den_q >> 1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_M0;
					end
				end
				S_M0: begin
					prod_q  <= prod;
					state_q <= S_M1;
				end
				S_M1: begin
					ev_x_q   <= x0_33[31:0];
					ev_sel_q <= EV_MID;
					state_q  <= S_E0;
				end
				S_UPD: begin
					if (f0_q == '0) begin
						res_root_q   <= ev_x_q;
						res_status_q <= ST_EXACT;
						res_iter_q   <= n_q;
						state_q      <= S_OUT;
					end else begin
						if (flo_q[63] != f0_q[63]) begin
							hi_q  <= ev_x_q;
							fhi_q <= f0_q;
						end else begin
							lo_q  <= ev_x_q;
							flo_q <= f0_q;
						end
						state_q <= S_C0;
					end
				end
				S_C0: begin
					prod_q  <= prod;
					state_q <= S_C1;
				end
				S_C1: begin
					if (lhs < prod_q) begin
						res_root_q   <= sum33[32:1];
						res_status_q <= ST_CONVERGED;
						res_iter_q   <= n_q;
						state_q      <= S_OUT;
					end else if (n_q == 11'(MAX_ITER)) begin
						res_root_q   <= ev_x_q;
						res_status_q <= ST_ITER_LIMIT;
						res_iter_q   <= n_q;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_SINIT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						root_q      <= res_root_q;
						status_q    <= res_status_q;
						iter_q      <= res_iter_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign root       = root_q;
	assign status     = status_q;
	assign iterations = iter_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second item while busy");

	a_bad_bracket_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_BRACKET |-> root == '0 && iterations == '0)
		else $error("bad bracket item carries a root or a step count");

	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ITER_LIMIT |-> iterations == 11'(MAX_ITER))
		else $error("iteration limit item with wrong step count");

	a_div_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");
`endif

endmodule
`default_nettype wire

// File: dv/quadratic_false_position_root_top_tb.sv
`timescale 1ns / 1ps
module quadratic_false_position_root_top_tb;
	import qfp_pkg::*;

	localparam int MAX_STEPS = 64;
	localparam int FRAC = 16;
	localparam logic signed [63:0] F_CLAMP = 64'sh2000_0000_0000_0000;

	typedef struct packed {
		logic [31:0] root;
		logic [1:0]  status;
		logic [10:0] iterations;
	} root_result_t;

	typedef struct {
		logic [31:0] lo;
		logic [31:0] hi;
		bit          fixed;
		root_result_t res;
	} bracket_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] bracket_low = '0, bracket_high = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] root;
	logic [1:0] status;
	logic [10:0] iterations;

	quadratic_false_position_root_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [63:0] ca = 1, cb = 0, cc = -1;
	logic [63:0] ctol = 66;
	root_result_t pending_roots[$];
	int errors = 0;
	int n_results = 0;
	int n_items = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	bit calm = 1'b0;

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [63:0] clamp_f(logic signed [63:0] v);
		if (v > F_CLAMP) return F_CLAMP;
		if (v < -F_CLAMP) return -F_CLAMP;
		return v;
	endfunction

	function automatic logic signed [63:0] poly_at(logic signed [63:0] x);
		logic [63:0] ax, sq, aa;
		logic signed [63:0] t2;
		ax = mag64(x);
		sq = (ax * ax) >> FRAC;
		aa = mag64(ca);
		if (aa != 0 && sq > 64'(F_CLAMP) / aa) t2 = F_CLAMP;
		else t2 = sq * aa;
		if (ca < 0) t2 = -t2;
		t2 = clamp_f(t2);
		return clamp_f(t2 + cb * x + (cc <<< FRAC));
	endfunction

	function automatic int sgn(logic signed [63:0] v);
		return (v > 0) - (v < 0);
	endfunction

	function automatic root_result_t find_root(logic [31:0] lo_in, logic [31:0] hi_in);
		logic signed [63:0] lo, hi, flo, fhi, x0, f0, dx, s, mid;
		logic [63:0] num, den, q, stp;
		root_result_t r;
		lo = $signed(lo_in);
		hi = $signed(hi_in);
		flo = poly_at(lo);
		fhi = poly_at(hi);
		x0 = lo;
		if (flo == 0) return '{lo_in, ST_EXACT, 11'd0};
		if (fhi == 0) return '{hi_in, ST_EXACT, 11'd0};
		if (sgn(flo) == sgn(fhi)) return '{32'd0, ST_BAD_BRACKET, 11'd0};
		for (int n = 1; n <= MAX_STEPS; n++) begin
			num = mag64(flo);
			den = num + mag64(fhi);
			dx = hi - lo;
			while (den >= 64'h8000_0000) begin
				den = den >> 1;
				num = num >> 1;
			end
			q = (num << 32) / den;
			stp = (128'(mag64(dx)) * 128'(q)) >> 32;
			x0 = dx < 0 ? lo - $signed(stp) : lo + $signed(stp);
			f0 = poly_at(x0);
			if (f0 == 0) return '{x0[31:0], ST_EXACT, 11'(n)};
			if (sgn(flo) != sgn(f0)) begin
				hi = x0;
				fhi = f0;
			end else begin
				lo = x0;
				flo = f0;
			end
			if ((mag64(hi - lo) << 16) < ctol * mag64(hi)) begin
				s = lo + hi;
				mid = s >= 0 ? s / 2 : -((-s + 1) / 2);
				return '{mid[31:0], ST_CONVERGED, 11'(n)};
			end
		end
		r = '{x0[31:0], ST_ITER_LIMIT, 11'(MAX_STEPS)};
		return r;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_COEF_SQUARE: ca = $signed(val);
			REG_COEF_LINEAR: cb = $signed(val);
			REG_COEF_CONSTANT: cc = $signed(val);
			default: ctol = val;
		endcase
	endtask

	task automatic set_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] t);
		in_valid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		write_reg(REG_COEF_SQUARE, a);
		write_reg(REG_COEF_LINEAR, b);
		write_reg(REG_COEF_CONSTANT, c);
		write_reg(REG_REL_TOLERANCE, t);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_bracket(logic [31:0] lo, logic [31:0] hi, bit fixed, root_result_t res);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		bracket_low <= lo;
		bracket_high <= hi;
		pending_roots.push_back(fixed ? res : find_root(lo, hi));
		n_items++;
		do @(posedge clk); while (!in_ready);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
			if (out_valid && out_ready) begin
				n_results++;
				if (pending_roots.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					root_result_t e;
					e = pending_roots.pop_front();
					status_seen[status]++;
					if (root !== e.root) begin
						$error("root exp %0d got %0d", $signed(e.root), $signed(root));
						errors++;
					end
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status);
						errors++;
					end
					if (iterations !== e.iterations) begin
						$error("iterations exp %0d got %0d", e.iterations, iterations);
						errors++;
					end
				end
			end
		end
	end

	bracket_row_t bracket_table[] = '{
		'{32'h0001_0000, 32'h0002_0000, 1'b1, '{32'h0001_0000, ST_EXACT, 11'd0}},
		'{32'h0000_0000, 32'hffff_0000, 1'b1, '{32'hffff_0000, ST_EXACT, 11'd0}},
		'{32'h0002_0000, 32'h0003_0000, 1'b1, '{32'd0, ST_BAD_BRACKET, 11'd0}},
		'{32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'd0, ST_BAD_BRACKET, 11'd0}},
		'{32'h0000_0000, 32'h0003_0000, 1'b0, '{default: '0}},
		'{32'h0003_0000, 32'h0000_0000, 1'b0, '{default: '0}},
		'{32'h0000_8000, 32'h0001_8000, 1'b0, '{default: '0}},
		'{32'h8000_0000, 32'h0000_0000, 1'b0, '{default: '0}},
		'{32'h0000_0000, 32'h7fff_ffff, 1'b0, '{default: '0}},
		'{32'hfffe_0000, 32'h0000_0000, 1'b0, '{default: '0}}
	};

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			logic [31:0] lo, hi;
			case ($urandom_range(4))
				0: begin
					lo = $urandom;
					hi = $urandom;
				end
				1: begin
					lo = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
					hi = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
				end
				default: begin
					lo = 32'($signed($urandom_range(4 << 16)) - (4 << 16));
					hi = $urandom_range(6 << 16);
				end
			endcase
			send_bracket(lo, hi, 1'b0, '{default: '0});
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (bracket_table[i])
			send_bracket(bracket_table[i].lo, bracket_table[i].hi, bracket_table[i].fixed,
				bracket_table[i].res);
		// zero tolerance never converges
		set_coefs(16'd1, 16'd0, 16'hfffe, 16'd0);
		send_bracket(32'h0000_0000, 32'h0002_0000, 1'b0, '{default: '0});
		send_bracket(32'h0000_0000, 32'h0000_0000, 1'b1, '{32'd0, ST_BAD_BRACKET, 11'd0});
		set_coefs(16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
		random_phase(25);
		set_coefs(16'h8000, 16'h7fff, 16'h8000, 16'd1);
		random_phase(25);
		set_coefs(16'd1, 16'd0, 16'hfffe, 16'd66);
		calm = 1'b1;
		random_phase(25);
		calm = 1'b0;
		set_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)));
		random_phase(25);
		set_coefs(16'd3, 16'hfffb, 16'hfffe, 16'd300);
		random_phase(25);
		in_valid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d brackets sent, %0d results: exact %0d conv %0d bad %0d limit %0d",
			n_items, n_results, status_seen[0], status_seen[1], status_seen[2],
			status_seen[3]);
		$display("coefficient sets incl. extremes and zero tolerance were exercised");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
